>>> rtl/deadline_table_engine_top_assert.svh
// Assertion macros for the deadline table engine.
`ifndef DEADLINE_TABLE_ENGINE_TOP_ASSERT_SVH
`define DEADLINE_TABLE_ENGINE_TOP_ASSERT_SVH

// antecedent holds -> consequent holds in the next cycle
`define DTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// antecedent holds -> consequent holds in the same cycle
`define DTE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/dte_pkg.sv
// Shared types and constants of the deadline table engine.
`default_nettype none
package dte_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CUR_W  = $clog2(SLOTS + 1);
    localparam int DL_W   = 63;

    typedef enum logic [2:0] {
        OP_FIND_FREE = 3'd0,
        OP_WRITE     = 3'd1,
        OP_EARLIEST  = 3'd2,
        OP_COUNT     = 3'd3,
        OP_NEXT      = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]      op;
        logic [3:0]      slot_index;
        logic [DL_W-1:0] new_deadline;
        logic [DL_W-1:0] now_time;
    } t_in;

    typedef struct packed {
        logic            found;
        logic [3:0]      result_index;
        logic [DL_W-1:0] result_deadline;
        logic [4:0]      active_count;
    } t_out;

    // control from the sequencer to the scan unit
    typedef struct packed {
        logic              start;
        logic              en;
        logic [SLOT_W-1:0] step;
        t_in               item;
    } t_scan_ctl;

endpackage
`default_nettype wire

>>> rtl/dte_cell.sv
// One slot of the deadline ring: holds a deadline, shifts it to its neighbor.
`default_nettype none
module dte_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_shift,
    input  wire logic [dte_pkg::DL_W-1:0]  i_shift_data,
    input  wire logic                      i_wr,
    input  wire logic [dte_pkg::DL_W-1:0]  i_wr_data,
    output logic      [dte_pkg::DL_W-1:0]  o_deadline
);

    logic [dte_pkg::DL_W-1:0] r_deadline;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadline <= '0;
        end else if (i_shift) begin
            r_deadline <= i_shift_data;
        end else if (i_wr) begin
            r_deadline <= i_wr_data;
        end
    end

    assign o_deadline = r_deadline;

endmodule
`default_nettype wire

>>> rtl/dte_scan.sv
// Scan unit: examines the slot at the head of the ring once per cycle while enabled.
`default_nettype none
module dte_scan (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire dte_pkg::t_scan_ctl       i_ctl,
    input  wire logic [dte_pkg::DL_W-1:0] i_head,
    output dte_pkg::t_out                 o_res
);

    logic [2:0]                   r_op;
    logic [dte_pkg::DL_W-1:0]     r_now;
    logic                         r_found, n_found;
    logic [dte_pkg::SLOT_W-1:0]   r_idx, n_idx;
    logic [dte_pkg::DL_W-1:0]     r_dl, n_dl;
    logic [dte_pkg::CUR_W-1:0]    r_cnt, n_cnt;
    logic [dte_pkg::CUR_W-1:0]    r_cursor, n_cursor;
    logic                         active;
    logic                         past_cursor;
    logic [dte_pkg::CUR_W-1:0]    step_ext;

    assign active      = (i_head != '0) && (i_head > r_now);
    assign step_ext    = dte_pkg::CUR_W'(i_ctl.step);
    assign past_cursor = (step_ext >= r_cursor);

    always_comb begin
        n_found  = r_found;
        n_idx    = r_idx;
        n_dl     = r_dl;
        n_cnt    = r_cnt;
        n_cursor = r_cursor;
        if (i_ctl.start) begin
            n_found = 1'b0;
            n_idx   = '0;
            n_dl    = '0;
            n_cnt   = '0;
            if (i_ctl.item.op == dte_pkg::OP_WRITE &&
                32'(i_ctl.item.slot_index) < dte_pkg::SLOTS) begin
                n_found = 1'b1;
                n_idx   = dte_pkg::SLOT_W'(i_ctl.item.slot_index);
                n_dl    = i_ctl.item.new_deadline;
            end
        end else if (i_ctl.en) begin
            unique case (r_op)
                dte_pkg::OP_FIND_FREE: begin
                    if (!r_found && !active) begin
                        n_found = 1'b1;
                        n_idx   = i_ctl.step;
                    end
                end
                dte_pkg::OP_EARLIEST: begin
                    if (active && (!r_found || i_head < r_dl)) begin
                        n_found = 1'b1;
                        n_idx   = i_ctl.step;
                        n_dl    = i_head;
                    end
                end
                dte_pkg::OP_COUNT: begin
                    if (active) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                dte_pkg::OP_NEXT: begin
                    // cursor moves past every slot examined, stops after a hit
                    if (!r_found && past_cursor) begin
                        n_cursor = step_ext + 1'b1;
                        if (active) begin
                            n_found = 1'b1;
                            n_idx   = i_ctl.step;
                            n_dl    = i_head;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_op  <= i_ctl.item.op;
            r_now <= i_ctl.item.now_time;
        end
        r_idx <= n_idx;
        r_dl  <= n_dl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found  <= 1'b0;
            r_cnt    <= '0;
            r_cursor <= '0;
        end else begin
            r_found  <= n_found;
            r_cnt    <= n_cnt;
            r_cursor <= n_cursor;
        end
    end

    assign o_res.found           = r_found;
    assign o_res.result_index    = 4'(r_idx);
    assign o_res.result_deadline = r_dl;
    assign o_res.active_count    = 5'(r_cnt);

endmodule
`default_nettype wire

>>> rtl/deadline_table_engine_top.sv
// Top level of the deadline table engine: slot ring, sequencer, output register.
// A write or an unused op goes from idle straight to the done state; a search (find
// free, earliest, count, next) first runs one full turn of the ring in the scan state.
// The slot ring turns once per cycle in the scan state past one shared scan unit; one
// item in work at a time, so a new input is taken only in the idle state.
// Reset (synchronous, active low) clears all slots, the read cursor and handshakes.
`default_nettype none
`include "deadline_table_engine_top_assert.svh"
module deadline_table_engine_top (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire dte_pkg::t_in    i_in,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output dte_pkg::t_out        o_out
);

    dte_pkg::t_state              r_state, n_state;
    logic [dte_pkg::SLOT_W-1:0]   r_step;
    logic                         r_out_valid;
    dte_pkg::t_out                r_out;
    dte_pkg::t_out                scan_res;
    dte_pkg::t_scan_ctl           ctl;
    logic                         in_ready;
    logic                         shift;
    logic                         load_out;
    logic                         start;
    logic                         is_search;
    logic                         last_step;
    logic                         wr_ok;
    logic [dte_pkg::DL_W-1:0]     cell_q [dte_pkg::SLOTS];

    assign start     = in_ready && i_in_valid;
    assign last_step = (32'(r_step) == dte_pkg::SLOTS - 1);
    assign is_search = (i_in.op == dte_pkg::OP_FIND_FREE) ||
                       (i_in.op == dte_pkg::OP_EARLIEST) ||
                       (i_in.op == dte_pkg::OP_COUNT) ||
                       (i_in.op == dte_pkg::OP_NEXT);
    assign wr_ok     = start && (i_in.op == dte_pkg::OP_WRITE) &&
                       (32'(i_in.slot_index) < dte_pkg::SLOTS);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dte_pkg::S_IDLE: begin
                if (start) begin
                    n_state = is_search ? dte_pkg::S_SCAN : dte_pkg::S_DONE;
                end
            end
            dte_pkg::S_SCAN: begin
                if (last_step) begin
                    n_state = dte_pkg::S_DONE;
                end
            end
            dte_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = dte_pkg::S_IDLE;
                end
            end
            default: n_state = dte_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        in_ready = 1'b0;
        shift    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            dte_pkg::S_IDLE: in_ready = i_rst_n;
            dte_pkg::S_SCAN: shift    = 1'b1;
            dte_pkg::S_DONE: load_out = !r_out_valid || i_out_ready;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dte_pkg::S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // step wraps to zero after a full turn so the ring is home again
            if (shift) begin
                r_step <= last_step ? '0 : r_step + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= scan_res;
        end
    end

    // ring of slots: cell k takes from cell k+1, cell 0 is the head
    for (genvar k = 0; k < dte_pkg::SLOTS; k++) begin : g_cell
        dte_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (shift),
            .i_shift_data (cell_q[(k + 1) % dte_pkg::SLOTS]),
            .i_wr         (wr_ok && (32'(i_in.slot_index) == k)),
            .i_wr_data    (i_in.new_deadline),
            .o_deadline   (cell_q[k])
        );
    end

    assign ctl.start = start;
    assign ctl.en    = shift;
    assign ctl.step  = r_step;
    assign ctl.item  = i_in;

    dte_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_head  (cell_q[0]),
        .o_res   (scan_res)
    );

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `DTE_ASSERT_NEXT(a_search_enters_scan, start && is_search,
        r_state == dte_pkg::S_SCAN && r_step == '0, "search did not start at ring home")
    `DTE_ASSERT_NEXT(a_scan_full_turn, r_state == dte_pkg::S_SCAN && last_step,
        r_state == dte_pkg::S_DONE && r_step == '0, "ring not home after a full turn")
    `DTE_ASSERT_NEXT(a_done_waits, r_state == dte_pkg::S_DONE && r_out_valid && !i_out_ready,
        r_state == dte_pkg::S_DONE, "result dropped while output stalled")
    `DTE_ASSERT_SAME(a_ready_only_home, o_in_ready,
        r_step == '0 && !shift, "input taken while ring rotated")

endmodule
`default_nettype wire
